### hw/rtl/jhds_pkg.sv
// ----------------------------------------------------------------------------
// JPEG header scanner package
// Shared types and marker constants for the header dimension scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package jhds_pkg;

  // Parse position within the marker segment walk
  typedef enum logic [2:0] {
    PH_SOI0,
    PH_SOI1,
    PH_PREFIX,
    PH_CODE,
    PH_LEN0,
    PH_LEN1,
    PH_FRAME,
    PH_SKIP
  } phase_e;

  // Result status codes
  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_TRUNC     = 4'd1,
    ST_BADSTART  = 4'd2,
    ST_NOPREFIX  = 4'd3,
    ST_FFMARKER  = 4'd4,
    ST_SHORTLEN  = 4'd5,
    ST_EOI       = 4'd6,
    ST_ZEROSIZE  = 4'd7,
    ST_SHORTSOF  = 4'd8
  } status_e;

  localparam logic [7:0]  MarkerPrefix = 8'hFF;
  localparam logic [7:0]  CodeSoi      = 8'hD8;
  localparam logic [7:0]  CodeEoi      = 8'hD9;
  localparam logic [7:0]  CodeSos      = 8'hDA;
  localparam logic [15:0] MinSegLen    = 16'd2;
  localparam logic [15:0] MinSofLen    = 16'd7;

  // One byte beat of the stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;
  } beat_t;

  // One result beat
  typedef struct packed {
    status_e     status;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } result_t;

  // Frame header codes: C0..CF except C2, C4, C8, CC
  function automatic logic is_frame_code(input logic [7:0] code);
    logic in_range;
    in_range = (code[7:4] == 4'hC);
    return in_range && (code != 8'hC2) && (code != 8'hC4) &&
           (code != 8'hC8) && (code != 8'hCC);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/jpeg_header_dimension_scanner_top.sv
// ----------------------------------------------------------------------------
// JPEG header dimension scanner
// Parses JPEG marker segments byte by byte and reports image size at SOS, or an error status.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid_i/in_ready_o  | data_byte_i, first_byte_i, final_byte_i
//  out     | out_valid_o/out_ready_i| status_o, image_width_o, image_height_o
//
//  One byte beat per cycle while the output is not stalled; a byte waits in the
//  input register, then parse logic loads any result it decides into the output
//  register.
//  Reset clears the parse state; bytes after reset parse as a new file.
//  A stall on the output holds the input register, which then drops in_ready_o.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_header_dimension_scanner_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o
);
  import jhds_pkg::*;

  beat_t   in_beat, beat;
  logic    beat_valid;
  logic    space;
  logic    adv;
  logic    res_valid;
  result_t res, out_res;

  assign in_beat.data_byte  = data_byte_i;
  assign in_beat.first_byte = first_byte_i;
  assign in_beat.final_byte = final_byte_i;

  // Consume the held beat whenever the output side has room
  assign adv = beat_valid && space;

  jhds_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .beat_i       (in_beat),
    .consume_i    (adv),
    .beat_valid_o (beat_valid),
    .beat_o       (beat)
  );

  jhds_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .beat_i      (beat),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  jhds_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign status_o       = 4'(out_res.status);
  assign image_width_o  = out_res.image_width;
  assign image_height_o = out_res.image_height;

endmodule

`default_nettype wire

### hw/rtl/jhds_in_reg.sv
// ----------------------------------------------------------------------------
// JPEG header scanner input register
// Holds one accepted byte beat until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module jhds_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  jhds_pkg::beat_t beat_i,
  input  logic            consume_i,
  output logic            beat_valid_o,
  output jhds_pkg::beat_t beat_o
);
  import jhds_pkg::*;

  logic  valid_q;
  beat_t beat_q;

  // Take a new beat when empty or when the held one leaves this cycle
  assign in_ready_o   = !valid_q || consume_i;
  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      beat_q <= beat_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/jhds_parser.sv
// ----------------------------------------------------------------------------
// JPEG header scanner parse engine
// Walks the marker segments one byte per beat and decides the result.
// ----------------------------------------------------------------------------
`default_nettype none

module jhds_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  jhds_pkg::beat_t   beat_i,
  output logic              res_valid_o,
  output jhds_pkg::result_t res_o
);
  import jhds_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  marker_q, marker_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] left_q, left_d;
  logic [2:0]  field_q, field_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        done_q, done_d;

  // Current view after an optional restart
  phase_e      ph_c;
  logic [7:0]  mk_c, lh_c;
  logic [15:0] left_c, w_c, h_c;
  logic [2:0]  fld_c;
  logic        done_c;

  logic [15:0] seg_len;
  logic [15:0] left_dec;
  logic        hit;
  status_e     st;
  logic [7:0]  b;

  assign b = beat_i.data_byte;

  // Restart view: first byte clears everything before parsing
  always_comb begin
    if (beat_i.first_byte) begin
      ph_c = PH_SOI0; mk_c = '0; lh_c = '0; left_c = '0;
      fld_c = '0; w_c = '0; h_c = '0; done_c = 1'b0;
    end else begin
      ph_c = phase_q; mk_c = marker_q; lh_c = len_hi_q; left_c = left_q;
      fld_c = field_q; w_c = width_q; h_c = height_q; done_c = done_q;
    end
  end

  assign seg_len  = {lh_c, b};
  assign left_dec = (left_c != '0) ? left_c - 16'd1 : left_c;

  // Next state and result decision
  always_comb begin
    phase_d  = ph_c;
    marker_d = mk_c;
    len_hi_d = lh_c;
    left_d   = left_c;
    field_d  = fld_c;
    width_d  = w_c;
    height_d = h_c;
    done_d   = done_c;
    hit      = 1'b0;
    st       = ST_OK;

    if (!done_c) begin
      unique case (ph_c)
        PH_SOI0: begin
          marker_d = b;
          phase_d  = PH_SOI1;
        end
        PH_SOI1: begin
          if (mk_c != MarkerPrefix || b != CodeSoi) begin
            hit = 1'b1; st = ST_BADSTART;
          end else begin
            phase_d = PH_PREFIX;
          end
        end
        PH_PREFIX: begin
          if (b != MarkerPrefix) begin
            hit = 1'b1; st = ST_NOPREFIX;
          end else begin
            phase_d = PH_CODE;
          end
        end
        PH_CODE: begin
          if (b == MarkerPrefix) begin
            hit = 1'b1; st = ST_FFMARKER;
          end else begin
            marker_d = b;
            phase_d  = PH_LEN0;
          end
        end
        PH_LEN0: begin
          len_hi_d = b;
          phase_d  = PH_LEN1;
        end
        PH_LEN1: begin
          left_d = seg_len - MinSegLen;
          priority if (seg_len < MinSegLen) begin
            hit = 1'b1; st = ST_SHORTLEN;
          end else if (mk_c == CodeSos) begin
            hit = 1'b1;
            st  = (w_c != '0 && h_c != '0) ? ST_OK : ST_ZEROSIZE;
          end else if (mk_c == CodeEoi) begin
            hit = 1'b1; st = ST_EOI;
          end else if (is_frame_code(mk_c)) begin
            if (seg_len < MinSofLen) begin
              hit = 1'b1; st = ST_SHORTSOF;
            end else begin
              field_d = '0;
              phase_d = PH_FRAME;
            end
          end else begin
            phase_d = (seg_len == MinSegLen) ? PH_PREFIX : PH_SKIP;
          end
        end
        PH_FRAME: begin
          unique case (fld_c)
            3'd1:    height_d = {b, h_c[7:0]};
            3'd2:    height_d = {h_c[15:8], b};
            3'd3:    width_d  = {b, w_c[7:0]};
            3'd4:    width_d  = {w_c[15:8], b};
            default: ;
          endcase
          left_d = left_dec;
          if (fld_c >= 3'd4) begin
            phase_d = (left_dec == '0) ? PH_PREFIX : PH_SKIP;
          end else begin
            field_d = fld_c + 3'd1;
          end
        end
        PH_SKIP: begin
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = PH_PREFIX;
          end
        end
        default: ;
      endcase

      // Early end of data when this byte gave nothing
      if (!hit && beat_i.final_byte) begin
        hit = 1'b1; st = ST_TRUNC;
      end
      if (hit) begin
        done_d = 1'b1;
      end
    end
  end

  assign res_valid_o        = adv_i && hit;
  assign res_o.status       = st;
  assign res_o.image_width  = (st == ST_OK) ? w_c : '0;
  assign res_o.image_height = (st == ST_OK) ? h_c : '0;

  // Parse state: advance on each consumed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SOI0;
      marker_q <= '0;
      len_hi_q <= '0;
      left_q   <= '0;
      field_q  <= '0;
      width_q  <= '0;
      height_q <= '0;
      done_q   <= 1'b0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      marker_q <= marker_d;
      len_hi_q <= len_hi_d;
      left_q   <= left_d;
      field_q  <= field_d;
      width_q  <= width_d;
      height_q <= height_d;
      done_q   <= done_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/jhds_out_reg.sv
// ----------------------------------------------------------------------------
// JPEG header scanner output register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module jhds_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  jhds_pkg::result_t res_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output jhds_pkg::result_t res_o
);
  import jhds_pkg::*;

  logic    valid_q;
  result_t res_q;

  // Room for a new result when empty or draining this cycle
  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire
